[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SWM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("checker assertion failed");

// Check a property on every clock edge, reset included.
`define SWM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("checker assertion failed");

`endif

[rtl/swm_pkg.sv]
// Shared types and constants for the sliding window median block.
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COUNT_W     = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SAMPLE_W - COUNT_W;

  typedef struct packed {
    logic write;
    logic load;
    logic capt;
    logic scan;
    logic adv_cand;
    logic out_load;
  } swm_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
  } swm_sts_t;

endpackage

`default_nettype wire

[rtl/sliding_window_median.sv]
// Top level of the sliding window median filter.
// Each input beat is written to the window; candidates are then tried in turn, each loaded,
// captured and ranked against the valid entries, until the median is found, which is then
// registered to the output. A new input beat is taken only when idle, once the previous
// median has been loaded into a free output register.
// Reset: synchronous, clears the entry count, write slot, state and output valid.
`default_nettype none

module sliding_window_median #(
  parameter int WINDOW_SIZE = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [swm_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] sample
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [swm_pkg::OUT_TDATA_W-1:0]       out_tdata   // [15:0] median, [18:16] valid_count
);

  swm_pkg::swm_cmd_t                   cmd;
  swm_pkg::swm_sts_t                   sts;
  logic signed [swm_pkg::SAMPLE_W-1:0] out_median;
  logic [swm_pkg::COUNT_W-1:0]         out_count;

  swm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  swm_dp #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (in_tdata[swm_pkg::SAMPLE_W-1:0]),
    .out_median (out_median),
    .out_count  (out_count)
  );

  assign out_tdata = {{swm_pkg::OUT_PAD_W{1'b0}}, out_count, out_median};

endmodule

`default_nettype wire

[rtl/swm_ctrl.sv]
// Controller: sequences window write, candidate scans and result hand-off.
`default_nettype none

module swm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire swm_pkg::swm_sts_t sts,
  output swm_pkg::swm_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_CAPT = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_tvalid_r;
  logic   out_tvalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.write = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_CAPT;
      end
      S_CAPT: begin
        cmd.capt  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          if (sts.found) begin
            state_nxt = S_DONE;
          end else begin
            cmd.adv_cand = 1'b1;
            state_nxt    = S_LOAD;
          end
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/swm_dp.sv]
// Datapath: window memory, rank counters and result registers.
`default_nettype none

module swm_dp #(
  parameter int WINDOW_SIZE = 5
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire swm_pkg::swm_cmd_t                    cmd,
  output swm_pkg::swm_sts_t                         sts,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0]  in_sample,
  output logic signed [swm_pkg::SAMPLE_W-1:0]       out_median,
  output logic [swm_pkg::COUNT_W-1:0]               out_count
);

  localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = $clog2(WINDOW_SIZE + 1);

  logic signed [swm_pkg::SAMPLE_W-1:0] win_mem [WINDOW_SIZE];
  logic signed [swm_pkg::SAMPLE_W-1:0] rd_data_r;
  logic signed [swm_pkg::SAMPLE_W-1:0] cand_r;
  logic signed [swm_pkg::SAMPLE_W-1:0] out_median_r;
  logic [swm_pkg::COUNT_W-1:0]         out_count_r;
  logic [AW-1:0]                       wr_slot_r;
  logic [AW-1:0]                       cand_idx_r;
  logic [AW-1:0]                       rd_addr;
  logic [CW-1:0]                       count_r;
  logic [CW-1:0]                       scan_idx_r;
  logic [CW-1:0]                       less_r;
  logic [CW-1:0]                       leq_r;
  logic [CW-1:0]                       less_nxt;
  logic [CW-1:0]                       leq_nxt;
  logic [CW-1:0]                       rank;
  logic                                lt;
  logic                                le;

  assign rd_addr  = (cmd.capt || cmd.scan) ? scan_idx_r[AW-1:0] : cand_idx_r;
  assign lt       = (rd_data_r < cand_r);
  assign le       = (rd_data_r <= cand_r);
  assign less_nxt = less_r + CW'(lt);
  assign leq_nxt  = leq_r + CW'(le);
  assign rank     = count_r >> 1;

  assign sts.scan_last = (scan_idx_r == count_r);
  assign sts.found     = (less_nxt <= rank) && (rank < leq_nxt);

  assign out_median = out_median_r;
  assign out_count  = out_count_r;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      win_mem[wr_slot_r] <= in_sample;
    end
    rd_data_r <= win_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r <= '0;
      count_r   <= '0;
    end else if (cmd.write) begin
      wr_slot_r <= (wr_slot_r == AW'(WINDOW_SIZE - 1)) ? '0 : wr_slot_r + AW'(1);
      if (count_r != CW'(WINDOW_SIZE)) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      cand_idx_r <= '0;
    end else if (cmd.adv_cand) begin
      cand_idx_r <= cand_idx_r + AW'(1);
    end
    if (cmd.load) begin
      scan_idx_r <= '0;
      less_r     <= '0;
      leq_r      <= '0;
    end else if (cmd.capt) begin
      cand_r     <= rd_data_r;
      scan_idx_r <= scan_idx_r + CW'(1);
    end else if (cmd.scan) begin
      less_r     <= less_nxt;
      leq_r      <= leq_nxt;
      scan_idx_r <= scan_idx_r + CW'(1);
    end
    if (cmd.out_load) begin
      out_median_r <= cand_r;
      out_count_r  <= swm_pkg::COUNT_W'(count_r);
    end
  end

endmodule

`default_nettype wire

[rtl/swm_checker.sv]
// Port-level checker for the sliding window median block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module swm_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [swm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [swm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic in_beat;
  logic in_seen;

  assign in_beat = in_tvalid && in_tready;
  assign in_seen = ^in_tdata || !(^in_tdata);

  `SWM_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid)
  `SWM_ASSERT(a_busy_after_beat, clk, rst_n, in_beat && in_seen |=> !in_tready)
  `SWM_ASSERT(a_out_valid_holds, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `SWM_ASSERT(a_out_data_holds, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[verif/sliding_window_median_checker.sv]
// Checker: watches both streams, predicts each median and compares every output beat.
`timescale 1ns / 100ps

module sliding_window_median_checker #(
  parameter int WINDOW_SIZE = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [swm_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [swm_pkg::OUT_TDATA_W-1:0] out_tdata,  // [15:0] median, [18:16] valid_count
  output int                              fail_count,
  output int                              results_due
);

  typedef struct packed {
    logic signed [swm_pkg::SAMPLE_W-1:0] median;
    logic [swm_pkg::COUNT_W-1:0]         valid_count;
  } median_result_t;

  logic signed [swm_pkg::SAMPLE_W-1:0] window_q [WINDOW_SIZE];
  int                                  filled;
  int                                  wr_slot;
  median_result_t                      pending_medians [$];

  function automatic median_result_t next_median(
    logic signed [swm_pkg::SAMPLE_W-1:0] sample
  );
    logic signed [swm_pkg::SAMPLE_W-1:0] ordered [WINDOW_SIZE];
    logic signed [swm_pkg::SAMPLE_W-1:0] v;
    int                                  j;
    median_result_t                      res;
    window_q[wr_slot] = sample;
    wr_slot = (wr_slot + 1) % WINDOW_SIZE;
    if (filled < WINDOW_SIZE) filled++;
    // rank only the slots written so far
    for (int i = 0; i < filled; i++) begin
      v = window_q[i];
      j = i;
      while (j > 0 && ordered[j-1] > v) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = v;
    end
    res.median      = ordered[filled / 2];
    res.valid_count = swm_pkg::COUNT_W'(filled);
    return res;
  endfunction

  always @(posedge clk) begin
    median_result_t                      want;
    logic signed [swm_pkg::SAMPLE_W-1:0] got_median;
    logic [swm_pkg::COUNT_W-1:0]         got_count;
    logic [swm_pkg::OUT_PAD_W-1:0]       got_pad;
    got_median = out_tdata[swm_pkg::SAMPLE_W-1:0];
    got_count  = out_tdata[swm_pkg::SAMPLE_W+swm_pkg::COUNT_W-1:swm_pkg::SAMPLE_W];
    got_pad    = out_tdata[swm_pkg::OUT_TDATA_W-1 -: swm_pkg::OUT_PAD_W];
    if (!rst_n) begin
      filled  = 0;
      wr_slot = 0;
      pending_medians.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        pending_medians.push_back(next_median(in_tdata[swm_pkg::SAMPLE_W-1:0]));
      end
      if (out_tvalid && out_tready) begin
        if (pending_medians.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, got median %0d count %0d",
                   $time, got_median, got_count);
          fail_count++;
        end else begin
          want = pending_medians.pop_front();
          if (got_median !== want.median) begin
            $display("%0t: median mismatch, expected %0d, got %0d",
                     $time, want.median, got_median);
            fail_count++;
          end
          if (got_count !== want.valid_count) begin
            $display("%0t: valid_count mismatch, expected %0d, got %0d",
                     $time, want.valid_count, got_count);
            fail_count++;
          end
          if (got_pad !== '0) begin
            $display("%0t: tdata padding mismatch, expected 0, got %0h", $time, got_pad);
            fail_count++;
          end
        end
      end
    end
    results_due = pending_medians.size();
  end

endmodule

[verif/sliding_window_median_test.sv]
// Testbench top: clock, reset, sample stimulus, flow control and verdict for the median filter.
`timescale 1ns / 100ps

module sliding_window_median_test;

  localparam int WINDOW_SIZE   = 5;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS   = 440;
  localparam int HOLD_CYCLES   = 400;

  localparam logic signed [swm_pkg::SAMPLE_W-1:0] EDGE_SAMPLES [24] = '{
    16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
    16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005,
    16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
    16'sh5555, 16'shaaaa,
    16'sh0064, 16'sh0032, 16'sh0000, 16'shffce, 16'shff9c, 16'shff9c, 16'sh7fff
  };

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [swm_pkg::IN_TDATA_W-1:0]  in_tdata;   // [15:0] sample
  logic                            out_tvalid;
  logic                            out_tready;
  logic [swm_pkg::OUT_TDATA_W-1:0] out_tdata;  // [15:0] median, [18:16] valid_count

  int                                  fail_count;
  int                                  results_due;
  int                                  send_idle_pct = 0;
  int                                  recv_idle_pct = 0;
  int                                  hold_len      = 0;
  logic                                hold_flip     = 1'b0;
  int                                  quiet_cycles  = 0;
  logic signed [swm_pkg::SAMPLE_W-1:0] drift_center  = '0;

  sliding_window_median #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sliding_window_median_checker #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    int   hold_left;
    logic hold_seen;
    hold_left  = 0;
    hold_seen  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_flip !== hold_seen) begin
        hold_seen = hold_flip;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("** sliding_window_median: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [swm_pkg::SAMPLE_W-1:0] pick_sample();
    int mode;
    mode = $urandom_range(99);
    if (mode < 40) return swm_pkg::SAMPLE_W'($urandom);
    if (mode < 55) return swm_pkg::SAMPLE_W'($urandom_range(8) - 4);
    if (mode < 65) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'hffff;
        default: return 16'h0000;
      endcase
    end
    // cluster around a slowly moving centre so ties and near ties are common
    drift_center = drift_center + swm_pkg::SAMPLE_W'($urandom_range(200))
                   - swm_pkg::SAMPLE_W'(100);
    return drift_center + swm_pkg::SAMPLE_W'($urandom_range(6)) - swm_pkg::SAMPLE_W'(3);
  endfunction

  task automatic send_sample(input logic signed [swm_pkg::SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 17;
    recv_idle_pct = 60;
    foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);
    for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample());
    wait_results_drained();

    send_idle_pct = 60;
    recv_idle_pct = 17;
    for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample());
    wait_results_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == 150) begin
        hold_len  = HOLD_CYCLES;
        hold_flip = ~hold_flip;
      end
      if (i == 300) wait_results_drained();
      send_sample(pick_sample());
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fail_count == 0 && results_due == 0) begin
      $display("** sliding_window_median: PASSED **");
    end else begin
      $display("** sliding_window_median: FAILED **");
    end
    $finish;
  end

endmodule
